// File: hw/rtl/srd_pkg.sv
// Shared types and constants for the sensor record decoder.
// Used by sensor_record_decoder and its bench; depends on nothing.
`default_nettype none

package srd_pkg;

  localparam int VAL_W  = 49;
  localparam int ADDR_W = 4;
  localparam int IDX_W  = ADDR_W - 2;

  localparam logic [7:0] TYPE_ATTITUDE = 8'h01;
  localparam logic [7:0] TYPE_ANGLE    = 8'h02;
  localparam logic [7:0] TYPE_PRESSURE = 8'h03;

  localparam logic [7:0] SIGN_CODE_MAX = 8'h02;
  localparam logic [7:0] POINT_MAX     = 8'h03;

  localparam logic [IDX_W-1:0] REG_ATT_SCALE = 2'd0;
  localparam logic [IDX_W-1:0] REG_ANG_SCALE = 2'd1;
  localparam logic [IDX_W-1:0] REG_ANG_OFF   = 2'd2;

  localparam logic [31:0] ATT_SCALE_RST = 32'h0001_0000;
  localparam logic [31:0] ANG_SCALE_RST = 32'h0001_0000;
  localparam logic [15:0] ANG_OFF_RST   = 16'h0000;

  typedef enum logic [1:0] {
    KIND_UNKNOWN  = 2'd0,
    KIND_ATTITUDE = 2'd1,
    KIND_ANGLE    = 2'd2,
    KIND_PRESSURE = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    STAT_OK         = 2'd0,
    STAT_UNKNOWN    = 2'd1,
    STAT_BAD_SIGN   = 2'd2,
    STAT_BAD_POINT  = 2'd3
  } status_t;

  typedef struct packed {
    kind_t       kind;
    status_t     status;
    logic [1:0]  sign;
    logic        neg;
    logic        press_ok;
  } ctl_t;

  // reading arrives low byte first
  function automatic logic signed [15:0] swap16(input logic [15:0] h);
    return $signed({h[7:0], h[15:8]});
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/srd_press_div.sv
// Pressure scaling: rounded mag * 2^FRAC_BITS / 10^point by reciprocal multiply.
// Two stages (multiply, then add and shift); depends on nothing.
`default_nettype none

module srd_press_div #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic                    clk,
  input  wire logic [15:0]             mag,
  input  wire logic [1:0]              point,
  output logic      [FRAC_BITS+15:0]   quot
);

  localparam int X_W = FRAC_BITS + 16;
  localparam int K   = X_W + 10;
  localparam int M_W = K - 3;
  localparam int T_W = M_W + 16;
  localparam int S_W = T_W + FRAC_BITS + 1;

  localparam longint unsigned ONE_K = 64'd1 << K;
  localparam longint unsigned M10   = (ONE_K + 64'd9) / 10;
  localparam longint unsigned M100  = (ONE_K + 64'd99) / 100;
  localparam longint unsigned M1000 = (ONE_K + 64'd999) / 1000;
  localparam longint unsigned H10   = 64'd5 * M10;
  localparam longint unsigned H100  = 64'd50 * M100;
  localparam longint unsigned H1000 = 64'd500 * M1000;

  logic [M_W-1:0] m_sel;
  logic [T_W-1:0] t_nxt, t_r;
  logic [15:0]    mag_r;
  logic [1:0]     point_r;
  logic [K-1:0]   h_sel;
  logic [S_W-1:0] sum;

  always_comb begin
    unique case (point)
      2'd1:    m_sel = M_W'(M10);
      2'd2:    m_sel = M_W'(M100);
      2'd3:    m_sel = M_W'(M1000);
      default: m_sel = '0;
    endcase
  end

  assign t_nxt = T_W'(mag) * T_W'(m_sel);

  always_ff @(posedge clk) begin
    t_r     <= t_nxt;
    mag_r   <= mag;
    point_r <= point;
  end

  always_comb begin
    unique case (point_r)
      2'd1:    h_sel = K'(H10);
      2'd2:    h_sel = K'(H100);
      2'd3:    h_sel = K'(H1000);
      default: h_sel = '0;
    endcase
  end

  assign sum = (S_W'(t_r) << FRAC_BITS) + S_W'(h_sel);

  always_comb begin
    if (point_r == 2'd0) begin
      quot = X_W'(mag_r) << FRAC_BITS;
    end else begin
      quot = X_W'(sum >> K);
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/sensor_record_decoder.sv
// Sensor record decoder top level: APB register file, decode and multiply
// pipeline. Depends on srd_pkg and srd_press_div.
//
// One record is taken per cycle (busy stays low) and its result shows on the
// out_ ports with out_valid once it has passed the input register, the product
// register and the result register. The result is held for one cycle only,
// the receiver cannot stall. Pressure division by 10^point is a 16-bit by
// reciprocal multiply followed by a rounding add. The user must write registers
// through APB only while no record is in flight; the block does not enforce it.
`default_nettype none

module sensor_record_decoder #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  // request channel
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic [31:0]                 in_word_low,
  input  wire logic [31:0]                 in_word_high,
  // result channel
  output logic                             out_valid,
  output logic [1:0]                       out_record_kind,
  output logic [1:0]                       out_status,
  output logic signed [srd_pkg::VAL_W-1:0] out_value_first,
  output logic signed [srd_pkg::VAL_W-1:0] out_value_second,
  output logic signed [srd_pkg::VAL_W-1:0] out_value_third,
  output logic [1:0]                       out_sign_code,
  // configuration
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [srd_pkg::ADDR_W-1:0]  paddr,
  input  wire logic [31:0]                 pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready
);

  localparam int VW  = srd_pkg::VAL_W;
  localparam int Q_W = FRAC_BITS + 16;

  // config registers
  logic signed [31:0] att_scale_r;
  logic signed [31:0] ang_scale_r;
  logic [15:0]        ang_off_r;
  logic               cfg_wr;
  logic [srd_pkg::IDX_W-1:0] cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = paddr[srd_pkg::ADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      att_scale_r <= srd_pkg::ATT_SCALE_RST;
      ang_scale_r <= srd_pkg::ANG_SCALE_RST;
      ang_off_r   <= srd_pkg::ANG_OFF_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        srd_pkg::REG_ATT_SCALE: att_scale_r <= pwdata;
        srd_pkg::REG_ANG_SCALE: ang_scale_r <= pwdata;
        srd_pkg::REG_ANG_OFF:   ang_off_r   <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      srd_pkg::REG_ATT_SCALE: prdata = att_scale_r;
      srd_pkg::REG_ANG_SCALE: prdata = ang_scale_r;
      srd_pkg::REG_ANG_OFF:   prdata = {16'h0000, ang_off_r};
      default:                prdata = '0;
    endcase
  end

  // stage 1: input register
  logic        s1_valid_r;
  logic [31:0] lo_r, hi_r;
  logic        accept;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      lo_r <= in_word_low;
      hi_r <= in_word_high;
    end
  end

  // stage 1 decode and multiply
  logic signed [15:0] sw_hi, sw_lo0, sw_lo1;
  logic signed [16:0] diff_hi, diff_lo, op0, op1;
  logic signed [31:0] scale_sel;
  logic signed [VW-1:0] m0_nxt, m1_nxt;
  logic signed [VW-2:0] m2_nxt;
  logic [15:0]        mag;
  logic [7:0]         code, point;
  logic               is_att;
  srd_pkg::ctl_t      ctl_nxt;

  assign sw_hi  = srd_pkg::swap16(hi_r[31:16]);
  assign sw_lo0 = srd_pkg::swap16(lo_r[15:0]);
  assign sw_lo1 = srd_pkg::swap16(lo_r[31:16]);

  assign diff_hi = $signed({1'b0, lo_r[31:16]}) - $signed({1'b0, ang_off_r});
  assign diff_lo = $signed({1'b0, lo_r[15:0]})  - $signed({1'b0, ang_off_r});

  assign is_att    = (hi_r[7:0] == srd_pkg::TYPE_ATTITUDE);
  assign op0       = is_att ? 17'(sw_hi)  : diff_hi;
  assign op1       = is_att ? 17'(sw_lo0) : diff_lo;
  assign scale_sel = is_att ? att_scale_r : ang_scale_r;

  assign m0_nxt = VW'(op0) * VW'(scale_sel);
  assign m1_nxt = VW'(op1) * VW'(scale_sel);
  assign m2_nxt = (VW-1)'(sw_lo1) * (VW-1)'(att_scale_r);

  assign mag   = sw_lo1[15] ? $unsigned(-sw_lo1) : $unsigned(sw_lo1);
  assign point = lo_r[7:0];
  assign code  = lo_r[15:8];

  always_comb begin
    ctl_nxt          = '0;
    ctl_nxt.kind     = srd_pkg::KIND_UNKNOWN;
    ctl_nxt.status   = srd_pkg::STAT_OK;
    ctl_nxt.neg      = sw_lo1[15];
    unique case (hi_r[7:0])
      srd_pkg::TYPE_ATTITUDE: ctl_nxt.kind = srd_pkg::KIND_ATTITUDE;
      srd_pkg::TYPE_ANGLE:    ctl_nxt.kind = srd_pkg::KIND_ANGLE;
      srd_pkg::TYPE_PRESSURE: begin
        ctl_nxt.kind = srd_pkg::KIND_PRESSURE;
        priority if (code > srd_pkg::SIGN_CODE_MAX) begin
          ctl_nxt.status = srd_pkg::STAT_BAD_SIGN;
          ctl_nxt.sign   = 2'd1;
        end else if (point > srd_pkg::POINT_MAX) begin
          ctl_nxt.status = srd_pkg::STAT_BAD_POINT;
          ctl_nxt.sign   = code[1:0];
        end else begin
          ctl_nxt.sign     = code[1:0];
          ctl_nxt.press_ok = 1'b1;
        end
      end
      default: ctl_nxt.status = srd_pkg::STAT_UNKNOWN;
    endcase
  end

  // stage 2: product register
  logic                 s2_valid_r;
  logic signed [VW-1:0] m0_r, m1_r;
  logic signed [VW-2:0] m2_r;
  srd_pkg::ctl_t        ctl_r;
  logic [Q_W-1:0]       quot;

  srd_press_div #(
    .FRAC_BITS (FRAC_BITS)
  ) u_press_div (
    .clk   (clk),
    .mag   (mag),
    .point (point[1:0]),
    .quot  (quot)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    m0_r  <= m0_nxt;
    m1_r  <= m1_nxt;
    m2_r  <= m2_nxt;
    ctl_r <= ctl_nxt;
  end

  // result select
  logic signed [VW-1:0] q_ext, press_val;
  logic signed [VW-1:0] v0_nxt, v1_nxt, v2_nxt;

  assign q_ext     = VW'(quot);
  assign press_val = ctl_r.neg ? -q_ext : q_ext;

  always_comb begin
    v0_nxt = '0;
    v1_nxt = '0;
    v2_nxt = '0;
    unique case (ctl_r.kind)
      srd_pkg::KIND_ATTITUDE: begin
        v0_nxt = m0_r;
        v1_nxt = m1_r;
        v2_nxt = VW'(m2_r);
      end
      srd_pkg::KIND_ANGLE: begin
        v0_nxt = m0_r;
        v1_nxt = m1_r;
      end
      srd_pkg::KIND_PRESSURE: begin
        v0_nxt = ctl_r.press_ok ? press_val : '0;
      end
      default: ;
    endcase
  end

  // stage 3: result register
  logic                 out_valid_r;
  logic [1:0]           kind_r, status_r, sign_r;
  logic signed [VW-1:0] v0_r, v1_r, v2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    kind_r   <= ctl_r.kind;
    status_r <= ctl_r.status;
    sign_r   <= ctl_r.sign;
    v0_r     <= v0_nxt;
    v1_r     <= v1_nxt;
    v2_r     <= v2_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_record_kind  = kind_r;
  assign out_status       = status_r;
  assign out_sign_code    = sign_r;
  assign out_value_first  = v0_r;
  assign out_value_second = v1_r;
  assign out_value_third  = v2_r;

  // checks
  a_out_follows_s2: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(s2_valid_r))
    else $error("result strobe without a product stage entry");

  a_unknown_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status == srd_pkg::STAT_UNKNOWN) |->
      (out_record_kind == srd_pkg::KIND_UNKNOWN && v0_r == '0 && v1_r == '0 &&
       v2_r == '0 && out_sign_code == 2'd0))
    else $error("unknown record with nonzero payload");

  a_sign_only_pressure: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_record_kind != srd_pkg::KIND_PRESSURE) |->
      (out_sign_code == 2'd0))
    else $error("sign code set on a non-pressure record");

  a_bad_press_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_status == srd_pkg::STAT_BAD_SIGN ||
                     out_status == srd_pkg::STAT_BAD_POINT)) |->
      (v0_r == '0 && out_sign_code != 2'd3))
    else $error("rejected pressure record with a value");

endmodule

`default_nettype wire
